FILE: sv/fvpd_pkg.sv
// Shared types and fixed widths for the voltage-to-PWM-duty modulator.
// No dependencies; used by the top level, the sine/cosine ROM and the divider stage.
`default_nettype none

package fvpd_pkg;

  // Config port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Field widths
  localparam int VOLT_W   = 14;  // supply and phase limit, Q6.8 volts
  localparam int PERIOD_W = 16;  // pwm period and compare values
  localparam int UQ_W     = 15;  // torque voltage, signed Q7.8
  localparam int U2_W     = 15;  // clamped 2*Uq, signed Q7.8
  localparam int TRIG_W   = 16;  // sine/cosine, signed Q1.15
  localparam int ROT_W    = 30;  // alpha/beta products

  // Phase math, scaled down by 8 from the 2^-41 V grid (113512 = 8 * 14189)
  localparam int SQRT3_Q13      = 14189;
  localparam int PH_W           = 47;
  localparam int MID_SHIFT      = 29;
  localparam int ALPHA_A_SHIFT  = 14;
  localparam int ALPHA_BC_SHIFT = 13;
  localparam int FRAC_SHIFT     = 30;
  localparam int V_W            = VOLT_W + FRAC_SHIFT;

  // Duty scaling: V * period, split in two partial products
  localparam int SPLIT_W = 22;
  localparam int HI_W    = V_W - SPLIT_W;
  localparam int PP_W    = HI_W + PERIOD_W;
  localparam int SUM_W   = V_W + PERIOD_W;
  localparam int NUM_W   = SUM_W - FRAC_SHIFT;

  // Divider: numerator / supply, QUO_W quotient bits
  localparam int QUO_W        = 16;
  localparam int DIV_STEPS    = 2;
  localparam int DIV_STAGES   = QUO_W / DIV_STEPS;
  localparam int FRONT_STAGES = 8;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

  localparam int PHASES = 3;

  localparam logic [VOLT_W-1:0]   SUPPLY_RESET = 14'd2893;
  localparam logic [VOLT_W-1:0]   LIMIT_RESET  = 14'd3149;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2800;

  typedef enum logic [1:0] {
    REG_SUPPLY,
    REG_LIMIT,
    REG_PERIOD
  } reg_idx_t;

  typedef enum logic [1:0] {
    DUTY_DIV,
    DUTY_FULL,
    DUTY_ZERO
  } duty_code_t;

  typedef struct packed {
    logic [VOLT_W-1:0] rem;
    logic [QUO_W-1:0]  num;
    logic [QUO_W-1:0]  quo;
    duty_code_t        code;
  } div_lane_t;

endpackage

`default_nettype wire

FILE: sv/fvpd_sincos_rom.sv
// Sine and cosine lookup ROM, contents built at elaboration, registered reads.
// Depends on fvpd_pkg for the Q1.15 output width.
`default_nettype none

module fvpd_sincos_rom #(
  parameter int ENTRIES = 1024,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [IDX_W-1:0]                    idx,
  output logic signed [fvpd_pkg::TRIG_W-1:0]       sin_q,
  output logic signed [fvpd_pkg::TRIG_W-1:0]       cos_q
);
  import fvpd_pkg::*;

  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam int              TAYLOR_TERMS = 5;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110};

  typedef logic signed [TRIG_W-1:0] rom_t [ENTRIES];

  // Quarter-wave folded Taylor series to x^11, Q30 internally, rounded to Q1.15
  function automatic logic signed [TRIG_W-1:0] sine_q15(input logic [31:0] phase);
    logic [1:0]      quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned res;
    longint          sum;
    int              k;
    quad = phase[31:30];
    r    = 64'(phase[29:0]);
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 0; k < TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    res = (64'(sum) + 64'd16384) >> 15;
    if (res > 64'd32767) begin
      res = 64'd32767;
    end
    return quad[1] ? TRIG_W'(-res) : TRIG_W'(res);
  endfunction

  function automatic rom_t build_rom(input logic cosine);
    rom_t            tab;
    logic [31:0]     ph;
    longint unsigned wide;
    int              i;
    for (i = 0; i < ENTRIES; i++) begin
      wide = (64'(i) << 32) / ENTRIES;
      ph   = wide[31:0];
      if (cosine) begin
        ph = ph + 32'h4000_0000;
      end
      tab[i] = sine_q15(ph);
    end
    return tab;
  endfunction

  localparam rom_t SIN_ROM = build_rom(1'b0);
  localparam rom_t COS_ROM = build_rom(1'b1);

  logic signed [TRIG_W-1:0] sin_r;
  logic signed [TRIG_W-1:0] cos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= SIN_ROM[idx];
      cos_r <= COS_ROM[idx];
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

`default_nettype wire

FILE: sv/fvpd_div_stage.sv
// One restoring-division stage: DIV_STEPS quotient bits per register stage.
// Depends on fvpd_pkg for div_lane_t and widths.
`default_nettype none

module fvpd_div_stage (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [fvpd_pkg::VOLT_W-1:0]   divisor,
  input  wire fvpd_pkg::div_lane_t           lane_i,
  output fvpd_pkg::div_lane_t                lane_o
);
  import fvpd_pkg::*;

  div_lane_t         acc;
  div_lane_t         lane_nxt;
  div_lane_t         lane_r;
  logic [VOLT_W:0]   trial;
  logic              qbit;

  always_comb begin
    acc   = lane_i;
    trial = '0;
    qbit  = 1'b0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {acc.rem, acc.num[QUO_W-1]};
      qbit  = (trial >= {1'b0, divisor});
      if (qbit) begin
        trial = trial - {1'b0, divisor};
      end
      acc.rem = trial[VOLT_W-1:0];
      acc.num = {acc.num[QUO_W-2:0], 1'b0};
      acc.quo = {acc.quo[QUO_W-2:0], qbit};
    end
    lane_nxt = acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

FILE: sv/foc_voltage_to_pwm_duty.sv
// Voltage-mode FOC modulator: inverse Park/Clarke plus sinusoidal PWM compares.
// One transaction accepted per cycle while in_stall is low.
// in_stall rises only when both output slots are full and the sink stalls.
// Sync active-low reset clears all valid bits and loads the register defaults.
// Depends on fvpd_pkg, fvpd_sincos_rom and fvpd_div_stage.
`default_nettype none

module foc_voltage_to_pwm_duty #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int ANGLE_BITS         = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [fvpd_pkg::UQ_W-1:0]       in_torque_voltage,
  input  wire logic [ANGLE_BITS-1:0]                  in_electrical_angle,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [fvpd_pkg::PERIOD_W-1:0]               out_compare_a,
  output logic [fvpd_pkg::PERIOD_W-1:0]               out_compare_b,
  output logic [fvpd_pkg::PERIOD_W-1:0]               out_compare_c,
  // config port
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [fvpd_pkg::CFG_ADDR_W-1:0]        paddr,
  input  wire logic [fvpd_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [fvpd_pkg::CFG_DATA_W-1:0]             prdata,
  output logic                                        pready
);
  import fvpd_pkg::*;

  // Pipeline map (one register stage each, common enable 'advance'):
  //   s1  angle -> table index, Uq doubled and clamped to +/- supply
  //   s2  sine/cosine ROM read
  //   s3  alpha = -U2*sin, beta = U2*cos
  //   s4  beta * sqrt(3) (Q13 after pulling out a common factor of 8)
  //   s5  three phase voltages around the mid-supply offset
  //   s6  clamp to [0, limit], classify: zero supply / full duty / divide
  //   s7  V * period as two 22x16 partial products
  //   s8  partial-product sum, drop 30 fraction bits (exact floor)
  //   s9..s16  restoring divide by supply, 2 quotient bits per stage
  // Then a 2-slot output buffer (out register + skid) so the pipe keeps
  // taking transactions while a result waits.

  localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
  localparam int PROD_W = ANGLE_BITS + IDX_W + 1;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [VOLT_W-1:0]   supply_r;
  logic [VOLT_W-1:0]   limit_r;
  logic [PERIOD_W-1:0] period_r;
  logic                cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RESET;
      limit_r  <= LIMIT_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_SUPPLY: supply_r <= pwdata[VOLT_W-1:0];
        REG_LIMIT:  limit_r  <= pwdata[VOLT_W-1:0];
        REG_PERIOD: period_r <= pwdata[PERIOD_W-1:0];
        default: ;  // unmapped offset, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SUPPLY: prdata = CFG_DATA_W'(supply_r);
      REG_LIMIT:  prdata = CFG_DATA_W'(limit_r);
      REG_PERIOD: prdata = CFG_DATA_W'(period_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: whole pipe moves together, frozen only while the skid
  // slot is occupied. Valid bits shift alongside the data.
  // ---------------------------------------------------------------------
  logic                   advance;
  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;
  logic                   skid_vld_r;

  assign advance  = !skid_vld_r;
  assign in_stall = skid_vld_r;
  assign vld_nxt  = {vld_r[PIPE_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // s1: index and voltage clamp
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0]       ang_prod;
  logic [IDX_W-1:0]        idx_nxt, idx_r;
  logic signed [U2_W:0]    u2_wide;
  logic signed [U2_W:0]    s_pos;
  logic signed [U2_W-1:0]  u2_nxt, u2_s1_r;

  always_comb begin
    // idx = floor(angle * entries / 2^ANGLE_BITS)
    ang_prod = PROD_W'(in_electrical_angle) * PROD_W'(SINE_TABLE_ENTRIES);
    idx_nxt  = ang_prod[ANGLE_BITS +: IDX_W];
    u2_wide  = {in_torque_voltage, 1'b0};
    s_pos    = signed'({2'b00, supply_r});
    if (u2_wide > s_pos) begin
      u2_nxt = U2_W'(s_pos);
    end else if (u2_wide < -s_pos) begin
      u2_nxt = U2_W'(-s_pos);
    end else begin
      u2_nxt = U2_W'(u2_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      idx_r   <= idx_nxt;
      u2_s1_r <= u2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // s2: trig lookup
  // ---------------------------------------------------------------------
  logic signed [TRIG_W-1:0] sin_q;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [U2_W-1:0]   u2_s2_r;

  fvpd_sincos_rom #(
    .ENTRIES (SINE_TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_rom (
    .clk   (clk),
    .en    (advance),
    .idx   (idx_r),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      u2_s2_r <= u2_s1_r;
    end
  end

  // ---------------------------------------------------------------------
  // s3: inverse Park (d = 0)
  // ---------------------------------------------------------------------
  logic signed [U2_W+TRIG_W-1:0] sprod, cprod;
  logic signed [ROT_W-1:0]       alpha_nxt, alpha_s3_r;
  logic signed [ROT_W-1:0]       beta_nxt, beta_s3_r;

  always_comb begin
    sprod     = u2_s2_r * sin_q;
    cprod     = u2_s2_r * cos_q;
    alpha_nxt = ROT_W'(-sprod);
    beta_nxt  = ROT_W'(cprod);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alpha_s3_r <= alpha_nxt;
      beta_s3_r  <= beta_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // s4: beta * sqrt(3)
  // ---------------------------------------------------------------------
  logic signed [PH_W-1:0] bk_nxt, bk_s4_r;
  logic signed [ROT_W-1:0] alpha_s4_r;

  assign bk_nxt = PH_W'(beta_s3_r) * PH_W'(SQRT3_Q13);

  always_ff @(posedge clk) begin
    if (advance) begin
      bk_s4_r    <= bk_nxt;
      alpha_s4_r <= alpha_s3_r;
    end
  end

  // ---------------------------------------------------------------------
  // s5: inverse Clarke plus offset, units of 2^-38 V
  // ---------------------------------------------------------------------
  logic signed [PH_W-1:0] mid;
  logic signed [PH_W-1:0] a_ext;
  logic signed [PH_W-1:0] ph_nxt  [PHASES];
  logic signed [PH_W-1:0] ph_s5_r [PHASES];

  always_comb begin
    mid       = signed'(PH_W'({supply_r, {MID_SHIFT{1'b0}}}));
    a_ext     = PH_W'(alpha_s4_r);
    ph_nxt[0] = (a_ext <<< ALPHA_A_SHIFT) + mid;
    ph_nxt[1] = bk_s4_r - (a_ext <<< ALPHA_BC_SHIFT) + mid;
    ph_nxt[2] = -(a_ext <<< ALPHA_BC_SHIFT) - bk_s4_r + mid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ph_s5_r <= ph_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // s6: clamp and classify. Full duty when min(u, limit) >= supply, which
  // is u >= supply and limit >= supply, both checked in parallel.
  // ---------------------------------------------------------------------
  logic [V_W-1:0]    limit_v, full_v;
  logic              lim_ge_sup;
  logic              neg     [PHASES];
  logic [PH_W-2:0]   mag     [PHASES];
  logic [V_W-1:0]    v_nxt   [PHASES];
  logic [V_W-1:0]    v_s6_r  [PHASES];
  duty_code_t        code_nxt   [PHASES];
  duty_code_t        code_s6_r  [PHASES];

  always_comb begin
    limit_v    = {limit_r, {FRAC_SHIFT{1'b0}}};
    full_v     = {supply_r, {FRAC_SHIFT{1'b0}}};
    lim_ge_sup = (limit_r >= supply_r);
    for (int p = 0; p < PHASES; p++) begin
      neg[p] = ph_s5_r[p][PH_W-1];
      mag[p] = ph_s5_r[p][PH_W-2:0];
      if (neg[p]) begin
        v_nxt[p] = '0;
      end else if (mag[p] > (PH_W-1)'(limit_v)) begin
        v_nxt[p] = limit_v;
      end else begin
        v_nxt[p] = mag[p][V_W-1:0];
      end
      if (supply_r == '0) begin
        code_nxt[p] = DUTY_ZERO;
      end else if (!neg[p] && lim_ge_sup && (mag[p] >= (PH_W-1)'(full_v))) begin
        code_nxt[p] = DUTY_FULL;
      end else begin
        code_nxt[p] = DUTY_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      v_s6_r    <= v_nxt;
      code_s6_r <= code_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // s7: V * period, two partial products per phase
  // ---------------------------------------------------------------------
  logic [PP_W-1:0] pph_nxt [PHASES];
  logic [PP_W-1:0] ppl_nxt [PHASES];
  logic [PP_W-1:0] pph_s7_r [PHASES];
  logic [PP_W-1:0] ppl_s7_r [PHASES];
  duty_code_t      code_s7_r [PHASES];

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      pph_nxt[p] = PP_W'(v_s6_r[p][V_W-1:SPLIT_W]) * PP_W'(period_r);
      ppl_nxt[p] = PP_W'(v_s6_r[p][SPLIT_W-1:0]) * PP_W'(period_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pph_s7_r  <= pph_nxt;
      ppl_s7_r  <= ppl_nxt;
      code_s7_r <= code_s6_r;
    end
  end

  // ---------------------------------------------------------------------
  // s8: numerator = floor(V * period / 2^30); floor then divide by supply
  // gives the same quotient as dividing by supply * 2^30 directly.
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0] psum    [PHASES];
  logic [NUM_W-1:0] num_nxt [PHASES];
  logic [NUM_W-1:0] num_s8_r [PHASES];
  duty_code_t       code_s8_r [PHASES];

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      psum[p]    = (SUM_W'(pph_s7_r[p]) << SPLIT_W) + SUM_W'(ppl_s7_r[p]);
      num_nxt[p] = psum[p][SUM_W-1 -: NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      num_s8_r  <= num_nxt;
      code_s8_r <= code_s7_r;
    end
  end

  // ---------------------------------------------------------------------
  // s9..s16: divide by supply. In the divide case numerator < supply*2^16,
  // so the top bits start below the divisor and 16 quotient bits suffice.
  // ---------------------------------------------------------------------
  div_lane_t dl [DIV_STAGES+1][PHASES];

  // Lane entry: rem = numerator top bits, num = low 16 bits, quo cleared
  for (genvar p = 0; p < PHASES; p++) begin : g_div_in
    assign dl[0][p] = {num_s8_r[p], {QUO_W{1'b0}}, code_s8_r[p]};
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    for (genvar p = 0; p < PHASES; p++) begin : g_lane
      fvpd_div_stage u_div (
        .clk     (clk),
        .en      (advance),
        .divisor (supply_r),
        .lane_i  (dl[j][p]),
        .lane_o  (dl[j+1][p])
      );
    end
  end

  // ---------------------------------------------------------------------
  // Result select and 2-slot output buffer
  // ---------------------------------------------------------------------
  logic [PERIOD_W-1:0] res_cmp     [PHASES];
  logic [PERIOD_W-1:0] out_cmp_nxt [PHASES];
  logic [PERIOD_W-1:0] out_cmp_r   [PHASES];
  logic [PERIOD_W-1:0] skid_cmp_r  [PHASES];
  logic                out_valid_r, out_valid_nxt;
  logic                skid_vld_nxt;
  logic                take;
  logic                load_out_pipe, load_out_skid, load_skid;

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      case (dl[DIV_STAGES][p].code)
        DUTY_FULL: res_cmp[p] = period_r;
        DUTY_ZERO: res_cmp[p] = '0;
        default:   res_cmp[p] = dl[DIV_STAGES][p].quo;
      endcase
    end
  end

  always_comb begin
    take          = out_valid_r && !out_stall;
    out_valid_nxt = out_valid_r;
    skid_vld_nxt  = skid_vld_r;
    load_out_pipe = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_vld_r) begin
      // pipe is frozen; drain skid into the out register
      if (take) begin
        load_out_skid = 1'b1;
        skid_vld_nxt  = 1'b0;
      end
    end else if (vld_r[PIPE_STAGES-1]) begin
      if (!out_valid_r || take) begin
        load_out_pipe = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
    for (int p = 0; p < PHASES; p++) begin
      out_cmp_nxt[p] = load_out_skid ? skid_cmp_r[p] : res_cmp[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_pipe || load_out_skid) begin
      out_cmp_r <= out_cmp_nxt;
    end
    if (load_skid) begin
      skid_cmp_r <= res_cmp;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_compare_a = out_cmp_r[0];
  assign out_compare_b = out_cmp_r[1];
  assign out_compare_c = out_cmp_r[2];

endmodule

`default_nettype wire

FILE: dv/foc_voltage_to_pwm_duty_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for foc_voltage_to_pwm_duty: random and directed
// transactions, APB register settings and back-pressure, checked against a local predictor.
// Depends on fvpd_pkg and the modulator RTL.

module foc_voltage_to_pwm_duty_test;
  import fvpd_pkg::*;

  // Pipeline depth of the modulator, plus timing knobs for the run.
  localparam int LATENCY     = 17;
  localparam int STALL_LIMIT = 3000;  // cycles without any transaction before giving up
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off, longer than the pipe
  localparam logic [1:0] REG_UNMAPPED = 2'd3;  // address 12, no register behind it

  // Q30 pi/2 used to turn a turn fraction into radians; sqrt(3) in Q16.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          SQRT3_Q16   = 64'sd113512;

  // One predicted result, with the transaction that caused it for debug prints.
  typedef struct {
    logic signed [UQ_W-1:0] torque;
    logic [15:0]            angle;
    logic [PERIOD_W-1:0]    a;
    logic [PERIOD_W-1:0]    b;
    logic [PERIOD_W-1:0]    c;
  } compare_set_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [UQ_W-1:0]        in_torque_voltage = '0;
  logic [15:0]                   in_electrical_angle = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [PERIOD_W-1:0]           out_compare_a;
  logic [PERIOD_W-1:0]           out_compare_b;
  logic [PERIOD_W-1:0]           out_compare_c;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]         paddr = '0;
  logic [CFG_DATA_W-1:0]         pwdata = '0;
  logic [CFG_DATA_W-1:0]         prdata;
  logic                          pready;

  // Testbench copy of the register file, updated when a write completes.
  logic [VOLT_W-1:0]   model_supply = SUPPLY_RESET;
  logic [VOLT_W-1:0]   model_limit  = LIMIT_RESET;
  logic [PERIOD_W-1:0] model_period = PERIOD_RESET;

  compare_set_t pending_compares[$];

  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  bit hold_request    = 1'b0;
  int hold_left       = 0;

  foc_voltage_to_pwm_duty dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_torque_voltage   (in_torque_voltage),
    .in_electrical_angle (in_electrical_angle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_compare_a       (out_compare_a),
    .out_compare_b       (out_compare_b),
    .out_compare_c       (out_compare_c),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q1.15 sine of a 32-bit turn fraction: fold to the first quadrant, Taylor
  // series to x^11 in Q30 with truncation at every term, round, saturate.
  function automatic longint sin_lookup(input logic [31:0] turn);
    logic [1:0]       quadrant;
    longint unsigned  r, x, x2, term, divisor, rounded;
    longint           acc;
    int               k;
    quadrant = turn[31:30];
    r = {34'd0, turn[29:0]};
    if (quadrant[0]) r = 64'h4000_0000 - r;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    acc = $signed(x);
    for (k = 1; k <= 5; k++) begin
      divisor = (2 * k) * (2 * k + 1);
      term = ((term * x2) >> 30) / divisor;
      if (k % 2 == 1) acc -= $signed(term);
      else acc += $signed(term);
    end
    if (acc < 0) acc = 0;
    rounded = ($unsigned(acc) + 64'd16384) >> 15;
    if (rounded > 64'd32767) rounded = 64'd32767;
    return quadrant[1] ? -$signed(rounded) : $signed(rounded);
  endfunction

  // Phase voltage (2^-41 V units) to compare count: clamp to [0, limit],
  // saturate at full supply, otherwise scale by the period and truncate.
  function automatic logic [PERIOD_W-1:0] duty_count(input longint u,
                                                     input longint unsigned limit_u,
                                                     input longint unsigned full_u);
    longint unsigned v;
    v = (u < 0) ? 64'd0 : $unsigned(u);
    if (v > limit_u) v = limit_u;
    if (full_u == 0) return '0;  // zero supply
    if (v >= full_u) return model_period;
    return PERIOD_W'((v * model_period) / full_u);
  endfunction

  function automatic compare_set_t predict_compares(input logic signed [UQ_W-1:0] torque,
                                                    input logic [15:0] angle);
    compare_set_t    res;
    longint          s, u2, sn, cs, alpha, beta, mid;
    longint unsigned limit_u, full_u;
    logic [31:0]     turn;
    s = longint'(model_supply);
    // Table index is the top 10 angle bits; its phase is index * 2^22.
    turn = {angle[15:6], 22'd0};
    sn = sin_lookup(turn);
    cs = sin_lookup(turn + 32'h4000_0000);
    u2 = 2 * longint'(torque);
    if (u2 > s) u2 = s;
    if (u2 < -s) u2 = -s;
    alpha = -(u2 * sn);
    beta = u2 * cs;
    mid = s << 32;
    limit_u = 64'(model_limit) << 33;
    full_u = 64'(model_supply) << 33;
    res.torque = torque;
    res.angle = angle;
    res.a = duty_count(alpha * 131072 + mid, limit_u, full_u);
    res.b = duty_count(beta * SQRT3_Q16 - alpha * 65536 + mid, limit_u, full_u);
    res.c = duty_count(-alpha * 65536 - beta * SQRT3_Q16 + mid, limit_u, full_u);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors, receiver and watchdog
  // ---------------------------------------------------------------------------

  // Every accepted input transaction queues its expected compares.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_compares.push_back(predict_compares(in_torque_voltage, in_electrical_angle));
      items_sent++;
    end
  end

  task automatic check_field(input string name, input logic [PERIOD_W-1:0] want,
                             input logic [PERIOD_W-1:0] got, input compare_set_t src);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch (Uq %0d, angle %0d): expected %0d, actual %0d",
               $time, name, src.torque, src.angle, want, got);
    end
  endtask

  // Each accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    compare_set_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_compares.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual %0d %0d %0d",
                 $time, out_compare_a, out_compare_b, out_compare_c);
      end else begin
        want = pending_compares.pop_front();
        check_field("compare_a", want.a, out_compare_a, want);
        check_field("compare_b", want.b, out_compare_b, want);
        check_field("compare_c", want.c, out_compare_c, want);
        results_checked++;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side is a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_compares.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers; all are entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // Offer one transaction and wait until it is taken. Valid is left high so
  // back-to-back calls stream without a gap; drain_results drops it.
  task automatic send_transaction(input logic signed [UQ_W-1:0] torque,
                                  input logic [15:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_torque_voltage <= torque;
    in_electrical_angle <= angle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait for every expected result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_compares.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SUPPLY: model_supply = value[VOLT_W-1:0];
      REG_LIMIT:  model_limit = value[VOLT_W-1:0];
      REG_PERIOD: model_period = value[PERIOD_W-1:0];
      default: ;  // unmapped, ignored
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_read(input logic [1:0] idx, output logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [CFG_DATA_W-1:0] got, want;
    reg_read(idx, got);
    case (idx)
      REG_SUPPLY: want = CFG_DATA_W'(model_supply);
      REG_LIMIT:  want = CFG_DATA_W'(model_limit);
      default:    want = CFG_DATA_W'(model_period);
    endcase
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: register %0d readback: expected %0d, actual %0d",
               $time, idx, want, got);
    end
  endtask

  // Only called with the pipe empty.
  task automatic apply_settings(input logic [VOLT_W-1:0] supply,
                                input logic [VOLT_W-1:0] limit,
                                input logic [PERIOD_W-1:0] period);
    reg_write(REG_SUPPLY, CFG_DATA_W'(supply));
    reg_write(REG_LIMIT, CFG_DATA_W'(limit));
    reg_write(REG_PERIOD, CFG_DATA_W'(period));
    check_register(REG_SUPPLY);
    check_register(REG_LIMIT);
    check_register(REG_PERIOD);
    settings_used++;
  endtask

  // Mix of full-range codes, values around the half-supply clamp and small ones.
  function automatic logic signed [UQ_W-1:0] random_torque();
    int half, mag;
    half = int'(model_supply) / 2 + 2;
    case ($urandom_range(3))
      0: return UQ_W'($urandom);
      1: return UQ_W'(int'($urandom_range(2 * half)) - half);
      2: begin
        mag = half - 3 + int'($urandom_range(4));
        return UQ_W'($urandom_range(1) ? mag : -mag);
      end
      default: return UQ_W'(int'($urandom_range(255)) - 128);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values read back, then torque extremes, clamp edges and angles on
  // quadrant boundaries and table-step edges at the default settings.
  task automatic test_reset_defaults();
    logic signed [UQ_W-1:0] torques [12] = '{16383, -16384, 0, -1, 1, 1446,
                                            1447, -1447, 16383, -16384, 723, -723};
    logic [15:0] angles [12] = '{0, 65535, 16384, 32768, 49152, 63,
                                 64, 21845, 43690, 16383, 49151, 12345};
    check_register(REG_SUPPLY);
    check_register(REG_LIMIT);
    check_register(REG_PERIOD);
    settings_used++;
    foreach (torques[i]) send_transaction(torques[i], angles[i]);
    drain_results();
  endtask

  // Zero supply, zero period, limit above supply, zero limit, unmapped write.
  task automatic test_corner_settings();
    apply_settings(14'd0, LIMIT_RESET, PERIOD_RESET);
    send_transaction(-16384, 16'd0);
    send_transaction(16383, 16'd16384);
    send_transaction(15'sd5000, 16'd32768);
    drain_results();

    apply_settings(SUPPLY_RESET, LIMIT_RESET, 16'd0);
    send_transaction(16383, 16'd8000);
    send_transaction(-16384, 16'd40000);
    drain_results();

    // Limit far above supply: compares must still stop at the period.
    apply_settings(14'd1000, 14'd16383, 16'd65535);
    send_transaction(16383, 16'd0);
    send_transaction(-16384, 16'd16384);
    send_transaction(15'sd499, 16'd54613);
    drain_results();

    apply_settings(SUPPLY_RESET, 14'd0, 16'd65535);
    send_transaction(15'sd700, 16'd10000);
    send_transaction(-15'sd700, 16'd60000);
    drain_results();

    // Write to the unmapped address must leave every register alone.
    reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    check_register(REG_SUPPLY);
    check_register(REG_LIMIT);
    check_register(REG_PERIOD);
    send_transaction(15'sd1200, 16'd30000);
    drain_results();
  endtask

  // Three idle profiles, four register settings each: two realistic, one
  // anywhere in range and one built from the range ends.
  task automatic test_random_traffic();
    int phase_no, seg, n, s, l, p;
    for (phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin send_idle_pct = 21; recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        case (seg)
          1: begin
            s = $urandom_range(16383, 1);
            l = $urandom_range(16383);
            p = $urandom_range(65535, 1);
          end
          3: begin
            s = $urandom_range(1) ? 16383 : 1;
            l = $urandom_range(1) ? 16383 : 0;
            p = $urandom_range(1) ? 65535 : 1;
          end
          default: begin
            s = $urandom_range(6400, 256);
            l = $urandom_range(s * 3 / 2, s / 2);
            if (l > 16383) l = 16383;
            p = $urandom_range(10000, 500);
          end
        endcase
        apply_settings(VOLT_W'(s), VOLT_W'(l), PERIOD_W'(p));
        for (n = 0; n < 150; n++) send_transaction(random_torque(), 16'($urandom));
        drain_results();
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe fills and
  // in_stall must rise; then the sender waits for a full drain and resumes.
  task automatic test_output_holdoff();
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(SUPPLY_RESET, LIMIT_RESET, PERIOD_RESET);
    hold_request = 1'b1;
    for (n = 0; n < 40; n++) send_transaction(random_torque(), 16'($urandom));
    drain_results();
    recv_idle_pct = 30;
    for (n = 0; n < 10; n++) send_transaction(random_torque(), 16'($urandom));
    drain_results();
  endtask

  initial begin
    // Synchronous reset held from the start, released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_corner_settings();
    test_random_traffic();
    test_output_holdoff();

    // Quiet tail so a stray extra result would still be caught.
    repeat (LATENCY + 8) @(negedge clk);
    $display("Covered %0d transactions and %0d results over %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("including zero supply, zero period, limit above supply and a full-pipe stall.");
    if (mismatch_count == 0 && pending_compares.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, pending_compares.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
